@@ rtl/lsps_pkg.sv @@
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types, sizes and helpers for the LED strip pixel serializer.
// ----------------------------------------------------------------------------
package lsps_pkg;

    localparam int PIXEL_COUNT   = 32;
    localparam int CHANNEL_COUNT = 3;
    localparam int CHANNEL_WIDTH = 8;
    localparam int PIXEL_BITS    = CHANNEL_COUNT * CHANNEL_WIDTH;

    localparam int PIX_IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int BIT_POS_W = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;

    localparam int COMMAND_W     = 2;
    localparam int INDEX_W       = 8;
    localparam int COLOR_W       = 8;
    localparam int PIXELS_USED_W = 6;
    localparam int LATCH_W       = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [PIXELS_USED_W-1:0] PIXELS_USED_RESET = PIXELS_USED_W'(32);
    localparam logic [LATCH_W-1:0]       LATCH_TICKS_RESET = LATCH_W'(1000);

    // Command field codes
    localparam logic [COMMAND_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_SET    = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [COMMAND_W-1:0] CMD_UPDATE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PIXELS_USED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LATCH_TICKS = 2'd1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef enum logic [3:0] {
        OP_TICK   = 4'b0001,
        OP_SET    = 4'b0010,
        OP_CLEAR  = 4'b0100,
        OP_UPDATE = 4'b1000
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [INDEX_W-1:0]   index;
        pixel_t               pixel;
    } item_t;

    // Channel 0 lands in the top bits; channels past blue are zero.
    function automatic pixel_t pack_pixel(logic [COLOR_W-1:0] r,
                                          logic [COLOR_W-1:0] g,
                                          logic [COLOR_W-1:0] b);
        pixel_t                   word;
        logic [CHANNEL_WIDTH-1:0] v;
        word = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            if (c == 0)
                v = CHANNEL_WIDTH'(r);
            else if (c == 1)
                v = CHANNEL_WIDTH'(g);
            else if (c == 2)
                v = CHANNEL_WIDTH'(b);
            else
                v = '0;
            word = (word << CHANNEL_WIDTH) | pixel_t'(v);
        end
        return word;
    endfunction

endpackage

@@ rtl/lsps_in_if.sv @@
// ----------------------------------------------------------------------------
// lsps_in_if
// Command channel: one beat per command (tick, set pixel, clear, update).
// ----------------------------------------------------------------------------
interface lsps_in_if import lsps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COMMAND_W-1:0] command;
    logic [INDEX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;

    modport source (output valid, command, pixel_index, red, green, blue,
                    input ready);
    modport sink   (input valid, command, pixel_index, red, green, blue,
                    output ready);
endinterface

@@ rtl/lsps_out_if.sv @@
// ----------------------------------------------------------------------------
// lsps_out_if
// Result channel: line levels and status after each command beat.
// ----------------------------------------------------------------------------
interface lsps_out_if import lsps_pkg::*; ();
    logic valid;
    logic ready;
    logic clock_line;
    logic data_line;
    logic busy_res;
    logic rejected;

    modport source (output valid, clock_line, data_line, busy_res, rejected,
                    input ready);
    modport sink   (input valid, clock_line, data_line, busy_res, rejected,
                    output ready);
endinterface

@@ rtl/lsps_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lsps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lsps_cfg_if import lsps_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lsps_front.sv @@
// ----------------------------------------------------------------------------
// lsps_front
// Accepts command beats, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lsps_front import lsps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lsps_in_if.sink   cmd,
    output item_t     q_item,
    output logic      q_valid,
    input  logic      q_pop
);

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   pop;
    item_t                  decoded;

    always_comb
    begin
        decoded.index = cmd.pixel_index;
        decoded.pixel = pack_pixel(cmd.red, cmd.green, cmd.blue);
        unique case (cmd.command)
            CMD_TICK:   decoded.op = OP_TICK;
            CMD_SET:    decoded.op = OP_SET;
            CMD_CLEAR:  decoded.op = OP_CLEAR;
            CMD_UPDATE: decoded.op = OP_UPDATE;
            default:    decoded.op = OP_TICK;
        endcase
    end

    assign cmd.ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= decoded;
    end

endmodule

@@ rtl/lsps_back.sv @@
// ----------------------------------------------------------------------------
// lsps_back
// Pixel store, serial line sequencer and result register.
// ----------------------------------------------------------------------------
module lsps_back import lsps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      q_item,
    input  logic       q_valid,
    output logic       q_pop,
    lsps_cfg_if.sink   cfg,
    lsps_out_if.source res
);

    pixel_t                 store_reg [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] valid_reg, valid_next;

    logic [PIXELS_USED_W-1:0] pixels_used_reg;
    logic [LATCH_W-1:0]       latch_ticks_reg;

    logic                   sending_reg, sending_next;
    logic [PIX_IDX_W-1:0]   pix_pos_reg, pix_pos_next;
    logic [BIT_POS_W-1:0]   bit_pos_reg, bit_pos_next;
    logic                   half_reg, half_next;
    logic [LATCH_W-1:0]     latch_cnt_reg, latch_cnt_next;
    logic                   clock_reg, clock_next;
    logic                   data_reg, data_next;

    logic                   res_valid_reg, res_valid_next;
    logic                   res_busy_reg, res_busy_next;
    logic                   res_rej_reg, res_rej_next;

    logic                   step;
    logic                   busy;
    logic                   idx_ok;
    logic                   write_en;
    logic [PIX_IDX_W-1:0]   write_addr;
    pixel_t                 cur_word;
    logic [BIT_POS_W-1:0]   bit_sel;

    assign cfg.ready = 1'b1;

    assign step  = q_valid && (!res_valid_reg || res.ready);
    assign q_pop = step;
    assign busy  = sending_reg || (latch_cnt_reg != '0);

    assign idx_ok = (32'(q_item.index) < 32'(pixels_used_reg))
                 && (32'(q_item.index) < PIXEL_COUNT);
    assign write_addr = PIX_IDX_W'(q_item.index);

    // Entries cleared by reset or a clear command read as zero
    assign cur_word = valid_reg[pix_pos_reg] ? store_reg[pix_pos_reg] : '0;
    assign bit_sel  = BIT_POS_W'(PIXEL_BITS - 1) - bit_pos_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        sending_next   = sending_reg;
        pix_pos_next   = pix_pos_reg;
        bit_pos_next   = bit_pos_reg;
        half_next      = half_reg;
        latch_cnt_next = latch_cnt_reg;
        clock_next     = clock_reg;
        data_next      = data_reg;
        res_valid_next = res_valid_reg;
        res_busy_next  = res_busy_reg;
        res_rej_next   = res_rej_reg;
        write_en       = 1'b0;

        if (step)
        begin
            res_rej_next = 1'b0;
            unique case (q_item.op)
                OP_TICK:
                begin
                    if (sending_reg)
                    begin
                        if (!half_reg)
                        begin
                            clock_next = 1'b0;
                            data_next  = cur_word[bit_sel];
                            half_next  = 1'b1;
                        end
                        else
                        begin
                            clock_next = 1'b1;
                            half_next  = 1'b0;
                            if (bit_pos_reg == BIT_POS_W'(PIXEL_BITS - 1))
                            begin
                                bit_pos_next = '0;
                                if (pix_pos_reg == PIX_IDX_W'(PIXEL_COUNT - 1))
                                begin
                                    pix_pos_next   = '0;
                                    sending_next   = 1'b0;
                                    latch_cnt_next = latch_ticks_reg;
                                end
                                else
                                begin
                                    pix_pos_next = pix_pos_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        clock_next = 1'b0;
                        if (latch_cnt_reg != '0)
                            latch_cnt_next = latch_cnt_reg - 1'b1;
                    end
                end
                OP_SET:
                begin
                    if (busy)
                        res_rej_next = 1'b1;
                    else if (idx_ok)
                    begin
                        write_en               = 1'b1;
                        valid_next[write_addr] = 1'b1;
                    end
                end
                OP_CLEAR, OP_UPDATE:
                begin
                    if (busy)
                        res_rej_next = 1'b1;
                    else
                    begin
                        if (q_item.op == OP_CLEAR)
                        begin
                            for (int i = 0; i < PIXEL_COUNT; i++)
                            begin
                                if (i < int'(pixels_used_reg))
                                    valid_next[i] = 1'b0;
                            end
                        end
                        sending_next   = 1'b1;
                        pix_pos_next   = '0;
                        bit_pos_next   = '0;
                        half_next      = 1'b0;
                        latch_cnt_next = '0;
                        clock_next     = 1'b0;
                    end
                end
                default:
                begin
                    res_rej_next = 1'b0;
                end
            endcase
            res_valid_next = 1'b1;
            res_busy_next  = sending_next || (latch_cnt_next != '0);
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            pixels_used_reg <= PIXELS_USED_RESET;
            latch_ticks_reg <= LATCH_TICKS_RESET;
            sending_reg     <= 1'b0;
            pix_pos_reg     <= '0;
            bit_pos_reg     <= '0;
            half_reg        <= 1'b0;
            latch_cnt_reg   <= '0;
            clock_reg       <= 1'b0;
            data_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_busy_reg    <= 1'b0;
            res_rej_reg     <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            sending_reg   <= sending_next;
            pix_pos_reg   <= pix_pos_next;
            bit_pos_reg   <= bit_pos_next;
            half_reg      <= half_next;
            latch_cnt_reg <= latch_cnt_next;
            clock_reg     <= clock_next;
            data_reg      <= data_next;
            res_valid_reg <= res_valid_next;
            res_busy_reg  <= res_busy_next;
            res_rej_reg   <= res_rej_next;
            if (cfg.valid)
            begin
                if (cfg.index == REG_PIXELS_USED)
                    pixels_used_reg <= PIXELS_USED_W'(cfg.data);
                else if (cfg.index == REG_LATCH_TICKS)
                    latch_ticks_reg <= LATCH_W'(cfg.data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
            store_reg[write_addr] <= q_item.pixel;
    end

    assign res.valid      = res_valid_reg;
    assign res.clock_line = clock_reg;
    assign res.data_line  = data_reg;
    assign res.busy_res   = res_busy_reg;
    assign res.rejected   = res_rej_reg;

endmodule

@@ rtl/led_strip_pixel_serializer_core.sv @@
// ----------------------------------------------------------------------------
// led_strip_pixel_serializer_core
// Two-wire LED strip driver: pixel store plus clock/data serializer.
// ----------------------------------------------------------------------------
// Each command beat (tick, set pixel, clear and update, update) yields one
// result beat carrying the strip clock and data levels, a busy flag and a
// reject flag for set, clear and update commands that arrive while busy. The
// block sustains one beat per clock while the result side is ready: a decoded
// command waits in a two-entry queue and then passes through the sequencer,
// which owns all line state; a command is registered in a queue slot and its
// result in the result register. A frame is 32 pixels x 24 bits, each bit two
// tick beats, followed by latch_ticks tick beats with the clock held low.
module led_strip_pixel_serializer_core import lsps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lsps_in_if.sink    cmd,
    lsps_out_if.source res,
    lsps_cfg_if.sink   cfg
);

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    lsps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    lsps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .res     (res)
    );

endmodule
